FILE: rtl/csmaca_pkg.sv
// shared types, codes and constants for the csma-ca transmit controller
package csmaca_pkg;

  // widths
  localparam int RANDOM_WIDTH = 8;
  localparam int UNIT_W       = 10;
  localparam int WAIT_W       = 18;
  localparam int PROD_W       = RANDOM_WIDTH + UNIT_W;
  localparam int CMP_W        = (PROD_W > WAIT_W) ? PROD_W : WAIT_W;
  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
  localparam logic [3:0] NB_CEIL = 4'd15;

  // phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BACKOFF = 3'd1;
  localparam logic [2:0] PH_CCA     = 3'd2;
  localparam logic [2:0] PH_TX      = 3'd3;
  localparam logic [2:0] PH_ACK     = 3'd4;

  // request kinds
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_TICK  = 3'd1;
  localparam logic [2:0] REQ_CCA   = 3'd2;
  localparam logic [2:0] REQ_TX    = 3'd3;
  localparam logic [2:0] REQ_ACK   = 3'd4;

  // actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_CCA   = 3'd1;
  localparam logic [2:0] ACT_TX    = 3'd2;
  localparam logic [2:0] ACT_AWAIT = 3'd3;
  localparam logic [2:0] ACT_DONE  = 3'd4;

  // completion status
  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_CAF     = 2'd1;
  localparam logic [1:0] ST_TX_ERR  = 2'd2;
  localparam logic [1:0] ST_NO_ACK  = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_MIN_BE     = 3'd0;
  localparam logic [2:0] CFG_MAX_BE     = 3'd1;
  localparam logic [2:0] CFG_MAX_NB     = 3'd2;
  localparam logic [2:0] CFG_RETRIES    = 3'd3;
  localparam logic [2:0] CFG_UNIT_TICKS = 3'd4;

  typedef struct packed {
    logic [3:0]        min_be;
    logic [3:0]        max_be;
    logic [3:0]        max_nb;
    logic [3:0]        retries;
    logic [UNIT_W-1:0] unit_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic [3:0]        retries_left;
    logic [3:0]        be;
    logic [3:0]        nb;
    logic [WAIT_W-1:0] wait_ticks;
    logic [1:0]        last_status;
    logic [7:0]        seq;
    logic              need_ack;
  } ctx_t;

  typedef struct packed {
    logic [2:0]              req_type;
    logic                    channel_busy;
    logic                    tx_failed;
    logic                    ack_received;
    logic                    ack_request;
    logic [RANDOM_WIDTH-1:0] random_value;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] status;
    logic [7:0] seq;
  } res_t;

endpackage

FILE: rtl/csmaca_step.sv
// next-state and result logic for one request
module csmaca_step import csmaca_pkg::*; (
  input  cfg_t  cfg,
  input  ctx_t  ctx,
  input  item_t item,
  output ctx_t  ctx_next,
  output res_t  res
);

  logic [4:0]              be_inc;
  logic [4:0]              nb_inc;
  logic [3:0]              be_busy;
  logic [3:0]              be_att;
  logic [RANDOM_WIDTH-1:0] draw;
  logic [PROD_W-1:0]       prod;
  logic [CMP_W-1:0]        prod_ext;
  logic [WAIT_W-1:0]       wait_att;
  logic [WAIT_W-1:0]       wait_dec;
  logic                    start_att;

  // exponent growth after a busy channel
  assign be_inc  = {1'b0, ctx.be} + 5'd1;
  assign nb_inc  = {1'b0, ctx.nb} + 5'd1;
  assign be_busy = (be_inc < {1'b0, cfg.max_be}) ? be_inc[3:0] : cfg.max_be;

  // exponent seen by a new attempt: start comes from idle, busy drop from cca
  assign be_att = (ctx.phase == PH_IDLE) ? cfg.min_be :
                  (ctx.phase == PH_CCA)  ? be_busy : ctx.be;

  // random draw masked to 2^be - 1
  always_comb begin
    for (int i = 0; i < RANDOM_WIDTH; i++) begin
      draw[i] = item.random_value[i] & (i < int'(be_att));
    end
  end

  // backoff length in ticks, saturated
  assign prod     = PROD_W'(draw) * PROD_W'(cfg.unit_ticks);
  assign prod_ext = CMP_W'(prod);
  assign wait_att = (prod_ext > CMP_W'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(prod_ext);
  assign wait_dec = (ctx.wait_ticks != '0) ? ctx.wait_ticks - WAIT_W'(1) : '0;

  // phase handling
  always_comb begin
    ctx_next   = ctx;
    res.action = ACT_NONE;
    res.status = ST_SUCCESS;
    start_att  = 1'b0;
    case (item.req_type)
      REQ_START: begin
        if (ctx.phase == PH_IDLE) begin
          ctx_next.need_ack     = item.ack_request;
          ctx_next.retries_left = cfg.retries;
          ctx_next.be           = cfg.min_be;
          ctx_next.nb           = 4'd0;
          ctx_next.last_status  = ST_CAF;
          start_att             = 1'b1;
        end
      end
      REQ_TICK: begin
        if (ctx.phase == PH_BACKOFF) begin
          ctx_next.wait_ticks = wait_dec;
          if (wait_dec == '0) begin
            ctx_next.phase = PH_CCA;
            res.action     = ACT_CCA;
          end
        end
      end
      REQ_CCA: begin
        if (ctx.phase == PH_CCA) begin
          if (!item.channel_busy) begin
            ctx_next.phase = PH_TX;
            res.action     = ACT_TX;
          end else begin
            ctx_next.be = be_busy;
            ctx_next.nb = nb_inc[4] ? NB_CEIL : nb_inc[3:0];
            if (nb_inc > {1'b0, cfg.max_nb}) begin
              ctx_next.last_status = ST_CAF;
              start_att            = 1'b1;
            end else begin
              res.action = ACT_CCA;
            end
          end
        end
      end
      REQ_TX: begin
        if (ctx.phase == PH_TX) begin
          if (item.tx_failed) begin
            ctx_next.last_status = ST_TX_ERR;
            start_att            = 1'b1;
          end else begin
            ctx_next.seq = ctx.seq + 8'd1;
            if (ctx.need_ack) begin
              ctx_next.phase = PH_ACK;
              res.action     = ACT_AWAIT;
            end else begin
              ctx_next.phase = PH_IDLE;
              res.action     = ACT_DONE;
            end
          end
        end
      end
      REQ_ACK: begin
        if (ctx.phase == PH_ACK) begin
          if (item.ack_received) begin
            ctx_next.phase = PH_IDLE;
            res.action     = ACT_DONE;
          end else begin
            ctx_next.last_status = ST_NO_ACK;
            start_att            = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // new attempt, or finish once the retries are spent
    if (start_att) begin
      if (ctx_next.retries_left == 4'd0) begin
        ctx_next.phase = PH_IDLE;
        res.action     = ACT_DONE;
        res.status     = ctx_next.last_status;
      end else begin
        ctx_next.retries_left = ctx_next.retries_left - 4'd1;
        ctx_next.wait_ticks   = wait_att;
        if (wait_att == '0) begin
          ctx_next.phase = PH_CCA;
          res.action     = ACT_CCA;
        end else begin
          ctx_next.phase = PH_BACKOFF;
          res.action     = ACT_NONE;
        end
      end
    end
    res.seq = ctx_next.seq;
  end

endmodule

FILE: rtl/csma_ca_transmit_controller_unit.sv
// top level of the unslotted csma-ca transmit controller
// a request is taken into the input register, and its result moves on into the
// result register that drives m_*; one request per cycle while m_tready holds; the
// two registers each hold one transfer, so a request is taken while a result waits
// reset: rst (synchronous, active high) empties both registers, loads register defaults
// and returns the controller to idle with sequence number zero
module csma_ca_transmit_controller_unit import csmaca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] channel_busy, [1] tx_failed, [2] ack_received, [3] ack_request,
  // [11:4] random_value, [15:12] zero
  input  logic [15:0] s_tdata,
  // [2:0] req_type
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [9:2] sequence_number, [15:10] zero
  output logic [15:0] m_tdata,
  // [2:0] action
  output logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  cfg_t  cfg;
  ctx_t  ctx;
  ctx_t  ctx_next;
  item_t s1_item;
  logic  s1_valid;
  res_t  res_next;
  res_t  out_res;
  logic  out_valid;
  logic  s1_go;
  logic  s_take;

  assign s1_go    = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_go;
  assign s_take   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_be     <= 4'd3;
      cfg.max_be     <= 4'd5;
      cfg.max_nb     <= 4'd4;
      cfg.retries    <= 4'd3;
      cfg.unit_ticks <= UNIT_W'(20);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_BE:     cfg.min_be     <= cfg_data[3:0];
        CFG_MAX_BE:     cfg.max_be     <= cfg_data[3:0];
        CFG_MAX_NB:     cfg.max_nb     <= cfg_data[3:0];
        CFG_RETRIES:    cfg.retries    <= cfg_data[3:0];
        CFG_UNIT_TICKS: cfg.unit_ticks <= cfg_data[UNIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      s1_item.req_type     <= s_tuser;
      s1_item.channel_busy <= s_tdata[0];
      s1_item.tx_failed    <= s_tdata[1];
      s1_item.ack_received <= s_tdata[2];
      s1_item.ack_request  <= s_tdata[3];
      s1_item.random_value <= s_tdata[4 +: RANDOM_WIDTH];
    end
  end

  csmaca_step u_step (
    .cfg      (cfg),
    .ctx      (ctx),
    .item     (s1_item),
    .ctx_next (ctx_next),
    .res      (res_next)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.phase        <= PH_IDLE;
      ctx.retries_left <= 4'd0;
      ctx.be           <= 4'd0;
      ctx.nb           <= 4'd0;
      ctx.wait_ticks   <= '0;
      ctx.last_status  <= ST_CAF;
      ctx.seq          <= 8'd0;
      ctx.need_ack     <= 1'b0;
    end else if (s1_go) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.action;
  assign m_tdata  = {6'd0, out_res.seq, out_res.status};

endmodule

FILE: rtl/csmaca_checker.sv
// port-level checks for the csma-ca transmit controller, bound to the top level
module csmaca_checker import csmaca_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  logic [7:0] last_seq;
  logic       have_seq;
  logic [7:0] cur_seq;

  assign cur_seq = m_tdata[9:2];

  // sequence number of the last result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      have_seq <= 1'b0;
      last_seq <= 8'd0;
    end else if (m_tvalid && m_tready) begin
      have_seq <= 1'b1;
      last_seq <= cur_seq;
    end
  end

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no result straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // status only with a finished send
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ACT_DONE |-> m_tdata[1:0] == ST_SUCCESS)
    else $error("status set without finish");

  // sequence advances by one, only on a good transmit
  a_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && have_seq && cur_seq != last_seq |->
      cur_seq == last_seq + 8'd1 && (m_tuser == ACT_AWAIT || m_tuser == ACT_DONE))
    else $error("sequence number jumped");

  // action codes stay in range
  a_action: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ACT_DONE)
    else $error("action out of range");

endmodule

bind csma_ca_transmit_controller_unit csmaca_checker u_csmaca_checker (.*);

FILE: sim/csma_ca_transmit_controller_unit_tb.sv
// testbench for the csma-ca transmit controller: directed table, then phase-aware random transfers
`timescale 1ns / 1ps

module csma_ca_transmit_controller_unit_tb;
  import csmaca_pkg::*;

  // request kind the controller never acts on
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  // flag bits for table rows, same order as the low bits of s_tdata
  localparam logic [3:0] F_BUSY = 4'b0001;
  localparam logic [3:0] F_FAIL = 4'b0010;
  localparam logic [3:0] F_ACK  = 4'b0100;
  localparam logic [3:0] F_WANT = 4'b1000;
  localparam logic [3:0] F_NONE = 4'b0000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [0] channel_busy, [1] tx_failed, [2] ack_received, [3] ack_request,
  // [11:4] random_value, [15:12] zero
  logic [15:0] s_tdata;
  // [2:0] req_type
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // [1:0] status, [9:2] sequence_number, [15:10] zero
  logic [15:0] m_tdata;
  // [2:0] action
  logic [2:0]  m_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;

  csma_ca_transmit_controller_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // one row of the directed table: a register write or an input transfer
  typedef struct packed {
    bit         is_write;
    logic [2:0] reg_idx;
    logic [9:0] reg_val;
    item_t      it;
    bit         typed;
    res_t       want;
  } plan_row_t;

  plan_row_t plan[$];
  res_t      pending_results[$];
  int        errors = 0;

  // stimulus shaping for the current phase of the run
  int busy_pct      = 50;
  int gap_pct       = 25;
  bit stall_on      = 1'b1;
  int setting_items = 0;

  // register copy used by the predictor
  logic [3:0]        cfg_min_be, cfg_max_be, cfg_max_nb, cfg_retries;
  logic [UNIT_W-1:0] cfg_unit;

  // predicted controller state
  logic [2:0]        ctl_phase;
  logic [3:0]        tries_left, bexp, busy_cnt;
  logic [WAIT_W-1:0] backoff_left;
  logic [1:0]        fail_code;
  logic [7:0]        seq_no;
  logic              ack_wanted;
  logic [2:0]        out_act;
  logic [1:0]        out_st;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("csma_ca_transmit_controller_unit verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // send ends: back to idle with a completion status
  function automatic void close_send(input logic [1:0] st);
    ctl_phase = PH_IDLE;
    out_act   = ACT_DONE;
    out_st    = st;
  endfunction

  // new attempt: spend a retry and draw the backoff, or give up
  function automatic void open_attempt(input logic [7:0] rnd);
    logic [7:0] mask;
    int         prod;
    if (tries_left == 4'd0) begin
      close_send(fail_code);
    end else begin
      tries_left = tries_left - 4'd1;
      mask = (bexp >= 4'd8) ? 8'hFF : 8'((1 << bexp) - 1);
      prod = int'(rnd & mask) * int'(cfg_unit);
      backoff_left = (prod > int'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(prod);
      if (backoff_left == '0) begin
        ctl_phase = PH_CCA;
        out_act   = ACT_CCA;
      end else begin
        ctl_phase = PH_BACKOFF;
        out_act   = ACT_NONE;
      end
    end
  endfunction

  // predictor: advance the state for one accepted transfer, return its result
  function automatic res_t step_controller(input item_t it);
    res_t r;
    int   grown, hits;
    out_act = ACT_NONE;
    out_st  = ST_SUCCESS;
    if (it.req_type == REQ_START && ctl_phase == PH_IDLE) begin
      ack_wanted = it.ack_request;
      tries_left = cfg_retries;
      bexp       = cfg_min_be;
      busy_cnt   = 4'd0;
      fail_code  = ST_CAF;
      open_attempt(it.random_value);
    end else if (it.req_type == REQ_TICK && ctl_phase == PH_BACKOFF) begin
      if (backoff_left != '0) backoff_left = backoff_left - 1'b1;
      if (backoff_left == '0) begin
        ctl_phase = PH_CCA;
        out_act   = ACT_CCA;
      end
    end else if (it.req_type == REQ_CCA && ctl_phase == PH_CCA) begin
      if (!it.channel_busy) begin
        ctl_phase = PH_TX;
        out_act   = ACT_TX;
      end else begin
        grown    = int'(bexp) + 1;
        bexp     = (grown < int'(cfg_max_be)) ? 4'(grown) : cfg_max_be;
        hits     = int'(busy_cnt) + 1;
        busy_cnt = (hits > 15) ? NB_CEIL : 4'(hits);
        // compare uses the count before the ceiling
        if (hits > int'(cfg_max_nb)) begin
          fail_code = ST_CAF;
          open_attempt(it.random_value);
        end else begin
          out_act = ACT_CCA;
        end
      end
    end else if (it.req_type == REQ_TX && ctl_phase == PH_TX) begin
      if (it.tx_failed) begin
        fail_code = ST_TX_ERR;
        open_attempt(it.random_value);
      end else begin
        seq_no = seq_no + 8'd1;
        if (ack_wanted) begin
          ctl_phase = PH_ACK;
          out_act   = ACT_AWAIT;
        end else begin
          close_send(ST_SUCCESS);
        end
      end
    end else if (it.req_type == REQ_ACK && ctl_phase == PH_ACK) begin
      if (it.ack_received) begin
        close_send(ST_SUCCESS);
      end else begin
        fail_code = ST_NO_ACK;
        open_attempt(it.random_value);
      end
    end
    r.action = out_act;
    r.status = out_st;
    r.seq    = seq_no;
    return r;
  endfunction

  // directed table rows
  function automatic void xfer(input logic [2:0] req, input logic [3:0] flags,
                               input logic [7:0] rnd, input bit typed,
                               input logic [2:0] act, input logic [1:0] st,
                               input logic [7:0] seq);
    plan_row_t row;
    row = '0;
    row.it.req_type     = req;
    row.it.channel_busy = flags[0];
    row.it.tx_failed    = flags[1];
    row.it.ack_received = flags[2];
    row.it.ack_request  = flags[3];
    row.it.random_value = rnd;
    row.typed           = typed;
    row.want.action     = act;
    row.want.status     = st;
    row.want.seq        = seq;
    plan.push_back(row);
  endfunction

  function automatic void reg_write(input logic [2:0] idx, input logic [9:0] val);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    plan.push_back(row);
  endfunction

  // random transfer, mostly the one the current phase is waiting for
  function automatic item_t pick_item();
    item_t it;
    it.channel_busy = ($urandom_range(1, 100) <= busy_pct);
    it.tx_failed    = ($urandom_range(1, 100) <= 25);
    it.ack_received = ($urandom_range(1, 100) <= 60);
    it.ack_request  = 1'($urandom_range(0, 1));
    it.random_value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      it.req_type = 3'($urandom_range(0, 7));
    end else begin
      case (ctl_phase)
        PH_BACKOFF: it.req_type = REQ_TICK;
        PH_CCA:     it.req_type = REQ_CCA;
        PH_TX:      it.req_type = REQ_TX;
        PH_ACK:     it.req_type = REQ_ACK;
        default:    it.req_type = REQ_START;
      endcase
    end
    return it;
  endfunction

  // one input transfer, with an optional gap first
  task automatic send_item(input item_t it, input bit typed, input res_t want);
    res_t predicted;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it.random_value, it.ack_request, it.ack_received,
                 it.tx_failed, it.channel_busy};
    s_tuser  <= it.req_type;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = step_controller(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MIN_BE:     cfg_min_be  = val[3:0];
      CFG_MAX_BE:     cfg_max_be  = val[3:0];
      CFG_MAX_NB:     cfg_max_nb  = val[3:0];
      CFG_RETRIES:    cfg_retries = val[3:0];
      CFG_UNIT_TICKS: cfg_unit    = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // register setting and stimulus shape for each random phase
  task automatic apply_setting(input int p);
    logic [3:0] mn, mx, nb, rt;
    logic [9:0] un;
    case (p)
      0: begin mn = 4'd0; mx = 4'd8; nb = 4'd15; rt = 4'd15; un = 10'd1;
               busy_pct = 85; gap_pct = 25; stall_on = 1'b1; setting_items = 300; end
      1: begin mn = 4'd0; mx = 4'd0; nb = 4'd2;  rt = 4'd2;  un = 10'd1023;
               busy_pct = 50; gap_pct = 25; stall_on = 1'b1; setting_items = 250; end
      2: begin mn = 4'd8; mx = 4'd0; nb = 4'd1;  rt = 4'd4;  un = 10'd1;
               busy_pct = 40; gap_pct = 30; stall_on = 1'b1; setting_items = 250; end
      3: begin mn = 4'd3; mx = 4'd5; nb = 4'd4;  rt = 4'd3;  un = 10'd2;
               busy_pct = 30; gap_pct = 0;  stall_on = 1'b1; setting_items = 300; end
      4: begin mn = 4'd2; mx = 4'd4; nb = 4'd0;  rt = 4'd15; un = 10'd3;
               busy_pct = 60; gap_pct = 25; stall_on = 1'b1; setting_items = 250; end
      5: begin mn = 4'd5; mx = 4'd6; nb = 4'd7;  rt = 4'd0;  un = 10'd4;
               busy_pct = 50; gap_pct = 20; stall_on = 1'b1; setting_items = 100; end
      default: begin mn = 4'd1; mx = 4'd3; nb = 4'd3; rt = 4'd7; un = 10'd1;
               busy_pct = 40; gap_pct = 0; stall_on = 1'b0; setting_items = 200; end
    endcase
    write_reg(CFG_MIN_BE,     {6'b0, mn});
    write_reg(CFG_MAX_BE,     {6'b0, mx});
    write_reg(CFG_MAX_NB,     {6'b0, nb});
    write_reg(CFG_RETRIES,    {6'b0, rt});
    write_reg(CFG_UNIT_TICKS, un);
  endtask

  // result side: check each transfer, stall in random bursts
  initial begin : result_side
    int   hold;
    res_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, action", m_tuser, 0);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser != want.action)
            report_mismatch("action", m_tuser, want.action);
          if (m_tdata[1:0] != want.status)
            report_mismatch("status", m_tdata[1:0], want.status);
          if (m_tdata[9:2] != want.seq)
            report_mismatch("sequence number", m_tdata[9:2], want.seq);
        end
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall_on && $urandom_range(1, 100) <= 8) begin
        hold = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    item_t it;
    int    live;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // register defaults and state after reset
    cfg_min_be   = 4'd3;
    cfg_max_be   = 4'd5;
    cfg_max_nb   = 4'd4;
    cfg_retries  = 4'd3;
    cfg_unit     = 10'd20;
    ctl_phase    = PH_IDLE;
    tries_left   = 4'd0;
    bexp         = 4'd0;
    busy_cnt     = 4'd0;
    backoff_left = '0;
    fail_code    = ST_CAF;
    seq_no       = 8'd0;
    ack_wanted   = 1'b0;

    // directed table, register defaults at first
    // stray items while idle are ignored
    xfer(REQ_TICK,   F_NONE, 8'h00, 1, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_UNUSED, F_NONE, 8'h00, 1, ACT_NONE, ST_SUCCESS, 8'd0);
    // send without ack, zero draw goes straight to cca
    xfer(REQ_START,  F_NONE, 8'h00, 1, ACT_CCA,  ST_SUCCESS, 8'd0);
    // start while busy is ignored
    xfer(REQ_START,  F_WANT, 8'hFF, 1, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_CCA,    F_NONE, 8'h00, 1, ACT_TX,   ST_SUCCESS, 8'd0);
    xfer(REQ_TX,     F_NONE, 8'h00, 1, ACT_DONE, ST_SUCCESS, 8'd1);
    // send with ack: busy channel, tx error, ack timeouts until retries run out
    xfer(REQ_START,  F_WANT, 8'hF8, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_CCA,    F_BUSY, 8'h55, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_CCA,    F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_TX,     F_FAIL, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_CCA,    F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_TX,     F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_ACK,    F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_CCA,    F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_TX,     F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_ACK,    F_NONE, 8'h00, 1, ACT_DONE, ST_NO_ACK,  8'd3);
    // zero retries: start finishes at once with channel access failure
    reg_write(CFG_RETRIES, 10'd0);
    xfer(REQ_START,  F_NONE, 8'h00, 1, ACT_DONE, ST_CAF,     8'd3);
    // one busy cca drops the only attempt
    reg_write(CFG_RETRIES, 10'd1);
    reg_write(CFG_MAX_NB, 10'd0);
    reg_write(CFG_MIN_BE, 10'd8);
    reg_write(CFG_MAX_BE, 10'd8);
    reg_write(CFG_UNIT_TICKS, 10'd1);
    xfer(REQ_START,  F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_CCA,    F_BUSY, 8'h00, 1, ACT_DONE, ST_CAF,     8'd3);
    // one tick of backoff, then a good send with ack
    reg_write(CFG_RETRIES, 10'd2);
    reg_write(CFG_MIN_BE, 10'd1);
    reg_write(CFG_MAX_BE, 10'd1);
    xfer(REQ_START,  F_WANT, 8'h01, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_TICK,   F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_CCA,    F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_TX,     F_NONE, 8'h00, 0, ACT_NONE, ST_SUCCESS, 8'd0);
    xfer(REQ_ACK,    F_ACK,  8'h00, 1, ACT_DONE, ST_SUCCESS, 8'd4);

    // reset
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    // random phases, one register setting each
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      apply_setting(p);
      live = 0;
      while (live < setting_items) begin
        it = pick_item();
        // only transfers the controller acts on count
        if ((it.req_type == REQ_START && ctl_phase == PH_IDLE) ||
            (it.req_type == REQ_TICK  && ctl_phase == PH_BACKOFF) ||
            (it.req_type == REQ_CCA   && ctl_phase == PH_CCA) ||
            (it.req_type == REQ_TX    && ctl_phase == PH_TX) ||
            (it.req_type == REQ_ACK   && ctl_phase == PH_ACK))
          live++;
        send_item(it, 1'b0, '0);
      end
    end

    // let the last results out, then a few quiet cycles
    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("csma_ca_transmit_controller_unit verification clean");
    end else begin
      $display("csma_ca_transmit_controller_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: csma_ca_transmit_controller_unit.f
rtl/csmaca_pkg.sv
rtl/csmaca_step.sv
rtl/csma_ca_transmit_controller_unit.sv
rtl/csmaca_checker.sv
sim/csma_ca_transmit_controller_unit_tb.sv
